/* rtl/core/scpc_pkg.sv */
// Shared types, constants and tables of the sidechain peak compressor.
package scpc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ENV_W = 24;
  localparam int MAX_CHANNELS_DEF = 32;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = 80;
  localparam int MUL_LEN_W = 6;

  localparam logic [15:0] DB_FLOOR_Q8 = 16'd46080;
  localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
  localparam logic [21:0] LOG2_PER_DB_Q24 = 22'd2786635;

  localparam logic [16:0] LOG2_TAB [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  localparam logic [16:0] EXP2_TAB [17] = '{
    17'd65536, 17'd62758, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  typedef enum logic [2:0] {
    REG_ATTACK    = 3'd0,
    REG_RELEASE   = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_SLOPE     = 3'd3,
    REG_MAKEUP    = 3'd4,
    REG_CHANNELS  = 3'd5,
    REG_SIDECHAIN = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [4:0]          channel;
    logic signed [23:0]  main_sample;
    logic signed [23:0]  sidechain_sample;
    logic                block_end;
  } item_t;

  typedef struct packed {
    logic signed [23:0]  comp_sample;
    logic [15:0]         gr_db;
    logic                block_end_out;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   mcand;
    logic [MUL_B_W-1:0]   mplier;
    logic [MUL_LEN_W-1:0] len;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

/* rtl/core/sidechain_peak_compressor.sv */
// Per-channel hard-knee peak compressor with optional sidechain control.
// One transaction is handled at a time. For an in-range item nine products go through
// one bit-serial multiplier at one multiplier bit per cycle, and the envelope
// normalisation shifts one bit per cycle. The next item can be taken as soon as the
// result is presented. A zero envelope skips the log stage and its two products. An
// item whose channel is out of range goes straight to the output stage. A finished
// result waits in an output register while the next transaction is accepted; a result
// that finds that register still full waits for it.
// Envelopes read as zero after reset with no clearing pass.
module sidechain_peak_compressor
  import scpc_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_M1, S_M2, S_NORM, S_M3, S_M4, S_CMP,
    S_M5, S_M6, S_M7, S_M8, S_M9, S_EMIT
  } state_t;

  state_t state;

  logic [23:0]        attack_coeff;
  logic [23:0]        release_coeff;
  logic signed [15:0] threshold_db;
  logic [15:0]        comp_slope;
  logic [15:0]        makeup_gain;
  logic [5:0]         channel_count;
  logic               use_sidechain;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff  <= 24'd16707456;
      release_coeff <= 24'd16773721;
      threshold_db  <= -16'sd6144;
      comp_slope    <= 16'd49152;
      makeup_gain   <= 16'd4096;
      channel_count <= 6'd2;
      use_sidechain <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:    attack_coeff  <= cfg_data;
        REG_RELEASE:   release_coeff <= cfg_data;
        REG_THRESHOLD: threshold_db  <= $signed(cfg_data[15:0]);
        REG_SLOPE:     comp_slope    <= cfg_data[15:0];
        REG_MAKEUP:    makeup_gain   <= cfg_data[15:0];
        REG_CHANNELS:  channel_count <= cfg_data[5:0];
        REG_SIDECHAIN: use_sidechain <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  scpc_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  logic             env_rd_en;
  logic [ENV_W-1:0] env_rd;
  logic             env_wr_en;
  logic [ENV_W-1:0] env_new;
  item_t            cur;

  scpc_env_store #(
    .DEPTH (MAX_CHANNELS),
    .AW    (CH_AW)
  ) u_env (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (env_rd_en),
    .rd_addr (CH_AW'(item.channel)),
    .rd_data (env_rd),
    .wr_en   (env_wr_en),
    .wr_addr (CH_AW'(cur.channel)),
    .wr_data (env_new)
  );

  logic [23:0]        coef_a;
  logic [24:0]        coef_b;
  logic [47:0]        p1;
  logic [23:0]        norm;
  logic [4:0]         lz;
  logic [3:0]         log_idx;
  logic signed [16:0] env_db;
  logic [15:0]        gr;
  logic [5:0]         exp_n;
  logic [3:0]         exp_idx;
  result_t            pend;

  logic               accept;
  logic               in_range;
  logic [23:0]        ctl;
  logic [23:0]        x_mag;
  logic [23:0]        main_mag;
  logic [48:0]        env_sum;
  logic [12:0]        log_d;
  logic [16:0]        frac;
  logic [21:0]        neg;
  logic [20:0]        neg_c;
  logic [40:0]        db_sum;
  logic [16:0]        dbn;
  logic [15:0]        dbn_c;
  logic [17:0]        ovr;
  logic [16:0]        over;
  logic [33:0]        gr_sum;
  logic [37:0]        t_sum;
  logic [21:0]        t_val;
  logic [11:0]        exp_d;
  logic [16:0]        g_val;
  logic [16:0]        gain;
  logic [57:0]        q_sum;
  logic [29:0]        q;
  logic [23:0]        sat;

  always_comb begin
    accept    = item_valid && item_ready;
    in_range  = ({1'b0, item.channel} < channel_count) && (32'(item.channel) < MAX_CHANNELS);
    env_rd_en = accept;
    ctl       = use_sidechain ? cur.sidechain_sample : cur.main_sample;
    x_mag     = ctl[23] ? (~ctl + 24'd1) : ctl;
    main_mag  = cur.main_sample[23] ? (~cur.main_sample + 24'd1) : cur.main_sample;
    coef_a    = (x_mag > env_rd) ? attack_coeff : release_coeff;
    env_sum   = {1'b0, p1} + mul_rsp.prod[48:0] + 49'h800000;
    env_new   = env_sum[47:24];
    env_wr_en = (state == S_M2) && mul_rsp.done;
    log_d     = 13'(LOG2_TAB[{1'b0, norm[22:19]} + 5'd1] - LOG2_TAB[norm[22:19]]);
    frac      = LOG2_TAB[log_idx] + 17'(mul_rsp.prod[39:27]);
    neg       = {1'b0, lz, 16'b0} - {5'b0, frac};
    neg_c     = neg[21] ? 21'd0 : neg[20:0];
    db_sum    = mul_rsp.prod[40:0] + 41'h800000;
    dbn       = db_sum[40:24];
    dbn_c     = (dbn > {1'b0, DB_FLOOR_Q8}) ? DB_FLOOR_Q8 : dbn[15:0];
    ovr       = {env_db[16], env_db} - {{2{threshold_db[15]}}, threshold_db};
    over      = (env_db > 17'(threshold_db)) ? ovr[16:0] : 17'd0;
    gr_sum    = {1'b0, mul_rsp.prod[32:0]} + 34'h8000;
    t_sum     = mul_rsp.prod[37:0] + 38'h8000;
    t_val     = t_sum[37:16];
    exp_d     = 12'(EXP2_TAB[t_val[15:12]] - EXP2_TAB[{1'b0, t_val[15:12]} + 5'd1]);
    g_val     = EXP2_TAB[exp_idx] - 17'(mul_rsp.prod[23:12]);
    gain      = (exp_n > 6'd16) ? 17'd0 : (g_val >> exp_n);
    q_sum     = mul_rsp.prod[57:0] + 58'h8000000;
    q         = q_sum[57:28];
    if (cur.main_sample[23]) begin
      sat = (q > 30'h800000) ? 24'h800000 : (~q[23:0] + 24'd1);
    end else begin
      sat = (q > 30'h7FFFFF) ? 24'h7FFFFF : q[23:0];
    end
  end

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      mul_req.start <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      if ((state == S_EMIT) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur <= item;
            pend.comp_sample   <= item.main_sample;
            pend.gr_db         <= '0;
            pend.block_end_out <= item.block_end;
            state <= in_range ? S_READ : S_EMIT;
          end
        end
        S_READ: begin
          coef_b        <= 25'h1000000 - {1'b0, coef_a};
          mul_req.start <= 1'b1;
          mul_req.mcand <= MUL_A_W'(env_rd);
          mul_req.mplier <= {coef_a, 8'b0};
          mul_req.len   <= MUL_LEN_W'(24);
          state         <= S_M1;
        end
        S_M1: begin
          if (mul_rsp.done) begin
            p1            <= mul_rsp.prod[47:0];
            mul_req.start <= 1'b1;
            mul_req.mcand <= MUL_A_W'(x_mag);
            mul_req.mplier <= {coef_b, 7'b0};
            mul_req.len   <= MUL_LEN_W'(25);
            state         <= S_M2;
          end
        end
        S_M2: begin
          if (mul_rsp.done) begin
            norm <= env_new;
            lz   <= '0;
            if (env_new == '0) begin
              env_db <= -17'sd46080;
              state  <= S_CMP;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (norm[23]) begin
            log_idx       <= norm[22:19];
            mul_req.start <= 1'b1;
            mul_req.mcand <= MUL_A_W'({norm[18:0], 8'b0});
            mul_req.mplier <= {log_d, 19'b0};
            mul_req.len   <= MUL_LEN_W'(13);
            state         <= S_M3;
          end else begin
            norm <= {norm[22:0], 1'b0};
            lz   <= lz + 5'd1;
          end
        end
        S_M3: begin
          if (mul_rsp.done) begin
            mul_req.start <= 1'b1;
            mul_req.mcand <= MUL_A_W'(neg_c);
            mul_req.mplier <= {DB_PER_LOG2_Q16, 13'b0};
            mul_req.len   <= MUL_LEN_W'(19);
            state         <= S_M4;
          end
        end
        S_M4: begin
          if (mul_rsp.done) begin
            env_db <= 17'sd0 - $signed({1'b0, dbn_c});
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          mul_req.start <= 1'b1;
          mul_req.mcand <= MUL_A_W'(over);
          mul_req.mplier <= {comp_slope, 16'b0};
          mul_req.len   <= MUL_LEN_W'(16);
          state         <= S_M5;
        end
        S_M5: begin
          if (mul_rsp.done) begin
            gr            <= gr_sum[31:16];
            mul_req.start <= 1'b1;
            mul_req.mcand <= MUL_A_W'(LOG2_PER_DB_Q24);
            mul_req.mplier <= {gr_sum[31:16], 16'b0};
            mul_req.len   <= MUL_LEN_W'(16);
            state         <= S_M6;
          end
        end
        S_M6: begin
          if (mul_rsp.done) begin
            exp_n         <= t_val[21:16];
            exp_idx       <= t_val[15:12];
            mul_req.start <= 1'b1;
            mul_req.mcand <= MUL_A_W'(t_val[11:0]);
            mul_req.mplier <= {exp_d, 20'b0};
            mul_req.len   <= MUL_LEN_W'(12);
            state         <= S_M7;
          end
        end
        S_M7: begin
          if (mul_rsp.done) begin
            mul_req.start <= 1'b1;
            mul_req.mcand <= MUL_A_W'(main_mag);
            mul_req.mplier <= {gain, 15'b0};
            mul_req.len   <= MUL_LEN_W'(17);
            state         <= S_M8;
          end
        end
        S_M8: begin
          if (mul_rsp.done) begin
            mul_req.start <= 1'b1;
            mul_req.mcand <= mul_rsp.prod[47:0];
            mul_req.mplier <= {makeup_gain, 16'b0};
            mul_req.len   <= MUL_LEN_W'(16);
            state         <= S_M9;
          end
        end
        S_M9: begin
          if (mul_rsp.done) begin
            pend.comp_sample <= sat;
            pend.gr_db       <= gr;
            state            <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result <= pend;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item_ready)
    else $error("transaction accepted while another is in flight");

  a_gr_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.gr_db <= 16'd32768))
    else $error("gain reduction out of range");

  a_mul_handover: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> !mul_req.start)
    else $error("multiplier restarted while finishing");

endmodule

/* rtl/core/scpc_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
module scpc_serial_mul
  import scpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [MUL_A_W-1:0]   mc;
  logic [MUL_B_W-1:0]   mq;
  logic [MUL_LEN_W-1:0] cnt;
  logic [MUL_P_W-1:0]   acc;
  logic                 busy;
  logic                 done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc  <= '0;
        mc   <= req.mcand;
        mq   <= req.mplier;
        cnt  <= req.len;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= {acc[MUL_P_W-2:0], 1'b0} + (mq[MUL_B_W-1] ? MUL_P_W'(mc) : '0);
        mq  <= {mq[MUL_B_W-2:0], 1'b0};
        cnt <= cnt - MUL_LEN_W'(1);
        if (cnt == MUL_LEN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

/* rtl/core/scpc_env_store.sv */
// Per-channel envelope memory with reset-cleared valid bits.
module scpc_env_store
  import scpc_pkg::*;
#(
  parameter int DEPTH = MAX_CHANNELS_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ENV_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ENV_W-1:0] wr_data
);

  logic [ENV_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [ENV_W-1:0] mem_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

/* tb/scpc_checker.sv */
// Checker for the sidechain peak compressor: predicts each result and compares.
module scpc_checker
  import scpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0] attack_q, release_q;
  logic signed [15:0] thresh_q;
  logic [15:0] slope_q, makeup_q;
  logic [5:0] nchan_q;
  logic side_q;
  logic [23:0] env_mem [32];
  result_t expected_q [$];

  function automatic logic signed [31:0] level_db(input logic [23:0] env);
    int p;
    logic [31:0] m, f, r;
    logic [63:0] frac, neg, dbneg;
    int idx;
    if (env == 0) return -32'sd46080;
    p = 0;
    while (p < 23 && (env >> (p + 1)) != 0) p++;
    m = 32'(env) << (31 - p);
    f = m - 32'h8000_0000;
    idx = int'(f[30:27]);
    r = f & 32'h07FF_FFFF;
    frac = 64'(LOG2_TAB[idx]) + ((64'(LOG2_TAB[idx+1] - LOG2_TAB[idx]) * 64'(r)) >> 27);
    neg = 64'(23 - p) * 64'd65536;
    neg = (neg < frac) ? 64'd0 : neg - frac;
    dbneg = (neg * 64'd394566 + 64'h80_0000) >> 24;
    if (dbneg > 64'd46080) dbneg = 64'd46080;
    return -$signed(32'(dbneg));
  endfunction

  function automatic logic [63:0] atten_gain(input logic [31:0] gr);
    logic [63:0] t, n, f, r, g;
    int idx;
    t = (64'(gr) * 64'd2786635 + 64'h8000) >> 16;
    n = t >> 16;
    f = t & 64'hFFFF;
    idx = int'(f >> 12);
    r = f & 64'hFFF;
    g = 64'(EXP2_TAB[idx]) - ((64'(EXP2_TAB[idx] - EXP2_TAB[idx+1]) * r) >> 12);
    if (n > 16) return 64'd0;
    return g >> n;
  endfunction

  function automatic result_t compress(input item_t it);
    result_t res;
    logic signed [63:0] ctl, mainv, over;
    logic [63:0] x, env, a, mag, q;
    logic signed [31:0] edb;
    logic [31:0] gr;
    res.block_end_out = it.block_end;
    if (6'(it.channel) >= nchan_q) begin
      res.comp_sample = it.main_sample;
      res.gr_db = '0;
      return res;
    end
    mainv = 64'(it.main_sample);
    ctl = side_q ? 64'(it.sidechain_sample) : mainv;
    x = ctl < 0 ? 64'(-ctl) : 64'(ctl);
    env = 64'(env_mem[it.channel]);
    a = (x > env) ? 64'(attack_q) : 64'(release_q);
    env = (a * env + ((64'd1 << 24) - a) * x + 64'h80_0000) >> 24;
    env_mem[it.channel] = env[23:0];
    edb = level_db(env[23:0]);
    gr = 0;
    if (edb > 32'(thresh_q)) begin
      over = 64'(edb) - 64'(thresh_q);
      gr = 32'((64'(over) * 64'(slope_q) + 64'h8000) >> 16);
    end
    mag = mainv < 0 ? 64'(-mainv) : 64'(mainv);
    q = (mag * atten_gain(gr) * 64'(makeup_q) + 64'h800_0000) >> 28;
    if (mainv < 0) res.comp_sample = (q > 64'd8388608) ? -24'sd8388608 : 24'(-$signed(q));
    else res.comp_sample = (q > 64'd8388607) ? 24'sd8388607 : 24'(q);
    res.gr_db = gr[15:0];
    return res;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      attack_q <= 24'd16707456;
      release_q <= 24'd16773721;
      thresh_q <= -16'sd6144;
      slope_q <= 16'd49152;
      makeup_q <= 16'd4096;
      nchan_q <= 6'd2;
      side_q <= 1'b0;
      for (int i = 0; i < 32; i++) env_mem[i] = '0;
      expected_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          REG_ATTACK:    attack_q <= cfg_data;
          REG_RELEASE:   release_q <= cfg_data;
          REG_THRESHOLD: thresh_q <= cfg_data[15:0];
          REG_SLOPE:     slope_q <= cfg_data[15:0];
          REG_MAKEUP:    makeup_q <= cfg_data[15:0];
          REG_CHANNELS:  nchan_q <= cfg_data[5:0];
          REG_SIDECHAIN: side_q <= cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        checked <= checked + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, result);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== result) begin
            $display("%0t: mismatch expected out=%0d gr=%0d end=%0b actual out=%0d gr=%0d end=%0b",
                     $realtime, exp_r.comp_sample, exp_r.gr_db, exp_r.block_end_out,
                     result.comp_sample, result.gr_db, result.block_end_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (item_valid && item_ready) expected_q.push_back(compress(item));
    end
  end

  assign pending = expected_q.size();
endmodule

/* tb/tb_sidechain_peak_compressor.sv */
// Top-level testbench of the sidechain peak compressor: stimulus and verdict.
module tb_sidechain_peak_compressor;
  import scpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready;
  item_t item;
  result_t result;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;
  int fail_count, pending, checked;
  int send_idle, recv_idle;
  int quiet_cycles;
  int sent;

  sidechain_peak_compressor uut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scpc_checker chk (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic cfg_idle();
    cfg_we <= 1'b0;
  endtask

  task automatic wait_empty();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_empty();
    repeat (250) @(posedge clk);
  endtask

  task automatic send(input logic [4:0] ch, input logic [23:0] m, input logic [23:0] s,
                      input logic be);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{channel: ch, main_sample: m, sidechain_sample: s, block_end: be};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  task automatic rand_item(input int nch, input bit loud);
    logic [23:0] m, s;
    logic [4:0] ch;
    m = 24'($urandom);
    s = 24'($urandom);
    if (!loud && $urandom_range(1)) begin
      m = 24'($signed(m) >>> $urandom_range(20));
      s = 24'($signed(s) >>> $urandom_range(20));
    end
    ch = ($urandom_range(15) == 0) ? 5'($urandom) : 5'($urandom_range(nch - 1));
    send(ch, m, s, 1'($urandom));
  endtask

  task automatic set_mode(input int phase);
    case (phase % 4)
      0: begin send_idle = 0; recv_idle = 0; end
      1: begin send_idle = 47; recv_idle = 0; end
      2: begin send_idle = 0; recv_idle = 47; end
      default: begin send_idle = 11; recv_idle = 11; end
    endcase
  endtask

  initial begin
    int nch;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 0;
    recv_idle = 0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(5'd0, 24'h7FFFFF, 24'h000000, 1'b0);
    send(5'd0, 24'h800000, 24'h7FFFFF, 1'b1);
    send(5'd1, 24'h000000, 24'h800000, 1'b0);
    send(5'd1, 24'h000001, 24'hFFFFFF, 1'b1);
    send(5'd2, 24'h123456, 24'h654321, 1'b0);
    send(5'd31, 24'h800000, 24'h800000, 1'b1);
    send(5'd0, 24'h000000, 24'h000000, 1'b0);
    drain();
    write_reg(REG_SIDECHAIN, 24'd1);
    write_reg(REG_CHANNELS, 24'd32);
    write_reg(REG_THRESHOLD, 24'hFFA000);
    write_reg(REG_SLOPE, 24'hFFFF);
    write_reg(REG_MAKEUP, 24'hFFFF);
    write_reg(REG_ATTACK, 24'd0);
    write_reg(REG_RELEASE, 24'hFFFFFF);
    write_reg(REG_SIDECHAIN, 24'd7);
    cfg_idle();
    send(5'd31, 24'h7FFFFF, 24'h800000, 1'b0);
    send(5'd31, 24'h800000, 24'h000000, 1'b1);
    send(5'd5, 24'h400000, 24'h7FFFFF, 1'b0);
    send(5'd5, 24'hC00000, 24'h000010, 1'b0);
    drain();
    write_reg(REG_THRESHOLD, 24'd0);
    write_reg(REG_MAKEUP, 24'd0);
    write_reg(REG_ATTACK, 24'hFFFFFF);
    write_reg(REG_RELEASE, 24'd0);
    cfg_idle();
    send(5'd6, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send(5'd6, 24'h000100, 24'h000000, 1'b0);
    drain();
    write_reg(REG_THRESHOLD, 24'hFFA000);
    write_reg(REG_SLOPE, 24'd0);
    write_reg(REG_MAKEUP, 24'd4096);
    cfg_idle();
    send(5'd7, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      set_mode(phase);
      nch = (phase == 3) ? 1 : (phase == 7) ? 32 : $urandom_range(1, 32);
      write_reg(REG_CHANNELS, 24'(nch));
      write_reg(REG_SIDECHAIN, 24'($urandom_range(1)));
      write_reg(REG_THRESHOLD, 24'($signed(-$urandom_range(24576))));
      write_reg(REG_SLOPE, (phase == 5) ? 24'hFFFF : 24'($urandom_range(65535)));
      write_reg(REG_MAKEUP, (phase == 6) ? 24'hFFFF : 24'($urandom_range(4096, 16384)));
      write_reg(REG_ATTACK, 24'($urandom_range(0, 16777215)));
      write_reg(REG_RELEASE, 24'($urandom_range(15000000, 16777215)));
      cfg_idle();
      for (int k = 0; k < 150; k++) begin
        rand_item(nch, ($urandom_range(3) == 0));
        if (k == 75) begin
          wait_empty();
          repeat ($urandom_range(10)) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d items over 12 random settings and directed extremes; %0d results checked.",
             sent, checked);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
